// File: hw/rtl/tt_pkg.sv
// Shared types and constants for the transposition table core.
// No dependencies; used by the interfaces, the clear sequencer and the top.
package tt_pkg;

   localparam int unsigned INDEX_W = 18;
   localparam int unsigned KEY_W   = 64;
   localparam int unsigned MOVE_W  = 16;
   localparam int unsigned SCORE_W = 16;
   localparam int unsigned WIN_W   = 17;
   localparam int unsigned DEPTH_W = 8;
   localparam int unsigned LIMIT_W = 15;

   localparam logic [LIMIT_W-1:0] SCORE_LIMIT_RESET = LIMIT_W'(32000);
   localparam logic [INDEX_W-1:0] LAST_INDEX        = {INDEX_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_PROBE = 2'd0,
      CMD_STORE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      BOUND_NONE  = 2'd0,
      BOUND_EXACT = 2'd1,
      BOUND_LOWER = 2'd2,
      BOUND_UPPER = 2'd3
   } bound_type;

   typedef enum logic {
      CLR_RUN   = 1'b0,
      CLR_SWEEP = 1'b1
   } clr_state_type;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score;
      logic signed [DEPTH_W-1:0] depth;
      logic [MOVE_W-1:0]         move;
      bound_type                 bound;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               busy;
      logic               wr_en;
      logic [INDEX_W-1:0] wr_addr;
   } clr_ctl_type;

endpackage

// File: hw/rtl/tt_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on tt_pkg for field widths.
interface tt_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        command;
   logic [tt_pkg::KEY_W-1:0]          position_key;
   logic signed [tt_pkg::DEPTH_W-1:0] remaining_depth;
   logic                              not_root;
   logic signed [tt_pkg::WIN_W-1:0]   window_low;
   logic signed [tt_pkg::WIN_W-1:0]   window_high;
   logic signed [tt_pkg::WIN_W-1:0]   best_score;
   logic [tt_pkg::MOVE_W-1:0]         best_move;

   modport source (output valid, command, position_key, remaining_depth, not_root,
                   window_low, window_high, best_score, best_move, input ready);
   modport sink   (input valid, command, position_key, remaining_depth, not_root,
                   window_low, window_high, best_score, best_move, output ready);
endinterface

interface tt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              hit;
   logic [tt_pkg::MOVE_W-1:0]         hash_move;
   logic                              cutoff;
   logic signed [tt_pkg::SCORE_W-1:0] cutoff_score;
   logic                              done_res;

   modport source (output valid, hit, hash_move, cutoff, cutoff_score, done_res,
                   input ready);
   modport sink   (input valid, hit, hash_move, cutoff, cutoff_score, done_res,
                   output ready);
endinterface

// File: hw/rtl/tt_ram.sv
// Generic simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module tt_ram #(
   parameter int unsigned ADDR_W = 18,
   parameter int unsigned DATA_W = 106
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tt_clear_ctl.sv
// Clear sequencer: walks every table slot once, writing an empty entry.
// Runs after reset and after a clear command. Depends on tt_pkg.
module tt_clear_ctl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output tt_pkg::clr_ctl_type ctl
);

   tt_pkg::clr_state_type        state_ff, state_in;
   logic [tt_pkg::INDEX_W-1:0]   idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tt_pkg::CLR_SWEEP;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      ctl.busy    = 1'b0;
      ctl.wr_en   = 1'b0;
      ctl.wr_addr = idx_ff;
      unique case (state_ff)
         tt_pkg::CLR_RUN: begin
            idx_in = '0;
            if (start) begin
               state_in = tt_pkg::CLR_SWEEP;
            end
         end
         tt_pkg::CLR_SWEEP: begin
            ctl.busy  = 1'b1;
            ctl.wr_en = 1'b1;
            if (idx_ff == tt_pkg::LAST_INDEX) begin
               state_in = tt_pkg::CLR_RUN;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = tt_pkg::CLR_RUN;
         end
      endcase
   end

endmodule

// File: hw/rtl/search_transposition_table_core.sv
// Direct-mapped, always-replace transposition table: 262144 slots of key, score, depth,
// move and bound in one synchronous RAM indexed by the low 18 key bits. Probes, stores
// and the unused command code are taken one beat per cycle unless the output stalls; a
// probe's response goes through the RAM's registered read and the lookup stage into the
// output register, and stores write the slot at the accepting edge so a following probe
// sees them. Clear, and likewise reset, sweep all 262144 slots, writing one empty slot
// per cycle; during the sweep no request is accepted, though csr writes still land. A
// clear's done response is issued at once and does not wait for the sweep.
// Depends on tt_pkg, tt_req_if, tt_rsp_if, tt_ram and tt_clear_ctl.
module search_transposition_table_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [tt_pkg::LIMIT_W-1:0] csr_wr_data,
   tt_req_if.sink                     req_if,
   tt_rsp_if.source                   rsp_if
);

   logic [tt_pkg::LIMIT_W-1:0] score_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_limit_ff <= tt_pkg::SCORE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         score_limit_ff <= csr_wr_data;
      end
   end

   // ---------------- accept stage ----------------
   tt_pkg::clr_ctl_type clr;
   logic                req_beat;
   logic                s1_fire;
   tt_pkg::cmd_type     req_cmd;

   logic                              s1_valid_ff, s1_valid_in;
   tt_pkg::cmd_type                   s1_cmd_ff;
   logic [tt_pkg::KEY_W-1:0]          s1_key_ff;
   logic signed [tt_pkg::DEPTH_W-1:0] s1_depth_ff;
   logic                              s1_not_root_ff;
   logic signed [tt_pkg::WIN_W-1:0]   s1_alpha_ff;
   logic signed [tt_pkg::WIN_W-1:0]   s1_beta_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_hit_ff;
   logic [tt_pkg::MOVE_W-1:0]         rsp_move_ff;
   logic                              rsp_cutoff_ff;
   logic signed [tt_pkg::SCORE_W-1:0] rsp_score_ff;
   logic                              rsp_done_ff;

   assign req_cmd   = tt_pkg::cmd_type'(req_if.command);
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !clr.busy && (!s1_valid_ff || s1_fire);
   assign req_beat  = req_if.valid && req_if.ready;

   tt_clear_ctl u_clear_ctl (
      .clock (clock),
      .reset (reset),
      .start (req_beat && (req_cmd == tt_pkg::CMD_CLEAR)),
      .ctl   (clr)
   );

   // store entry: clamped score, bound from the unclamped score
   logic signed [tt_pkg::WIN_W-1:0] lim_pos, lim_neg, clamped;
   tt_pkg::entry_type               st_entry;
   tt_pkg::entry_type               wr_entry;
   logic                            wr_en;
   logic [tt_pkg::INDEX_W-1:0]      wr_addr;
   logic [tt_pkg::INDEX_W-1:0]      req_idx;

   assign req_idx = req_if.position_key[tt_pkg::INDEX_W-1:0];
   assign lim_pos = $signed({2'b00, score_limit_ff});
   assign lim_neg = -lim_pos;

   always_comb begin
      priority if (req_if.best_score > lim_pos) begin
         clamped = lim_pos;
      end else if (req_if.best_score < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = req_if.best_score;
      end
      st_entry.key   = req_if.position_key;
      st_entry.score = clamped[tt_pkg::SCORE_W-1:0];
      st_entry.depth = req_if.remaining_depth;
      st_entry.move  = req_if.best_move;
      priority if (req_if.best_score <= req_if.window_low) begin
         st_entry.bound = tt_pkg::BOUND_UPPER;
      end else if (req_if.best_score >= req_if.window_high) begin
         st_entry.bound = tt_pkg::BOUND_LOWER;
      end else begin
         st_entry.bound = tt_pkg::BOUND_EXACT;
      end
   end

   // sweep and store never overlap: no beat is taken while the sweep runs
   always_comb begin
      if (clr.wr_en) begin
         wr_en    = 1'b1;
         wr_addr  = clr.wr_addr;
         wr_entry = '0;
      end else begin
         wr_en    = req_beat && (req_cmd == tt_pkg::CMD_STORE);
         wr_addr  = req_idx;
         wr_entry = st_entry;
      end
   end

   logic [tt_pkg::ENTRY_W-1:0] rd_bits;
   tt_pkg::entry_type          rd_entry;

   tt_ram #(
      .ADDR_W (tt_pkg::INDEX_W),
      .DATA_W (tt_pkg::ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (req_beat && (req_cmd == tt_pkg::CMD_PROBE)),
      .rd_addr (req_idx),
      .rd_data (rd_bits)
   );

   assign rd_entry = tt_pkg::entry_type'(rd_bits);

   // ---------------- lookup stage ----------------
   always_comb begin
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_cmd_ff      <= req_cmd;
         s1_key_ff      <= req_if.position_key;
         s1_depth_ff    <= req_if.remaining_depth;
         s1_not_root_ff <= req_if.not_root;
         s1_alpha_ff    <= req_if.window_low;
         s1_beta_ff     <= req_if.window_high;
      end
   end

   logic                              pr_hit, pr_cut, hit_c, cut_c, done_c;
   logic signed [tt_pkg::WIN_W-1:0]   st_score;
   logic [tt_pkg::MOVE_W-1:0]         move_c;
   logic signed [tt_pkg::SCORE_W-1:0] score_c;

   always_comb begin
      st_score = $signed({rd_entry.score[tt_pkg::SCORE_W-1], rd_entry.score});
      pr_hit   = (rd_entry.bound != tt_pkg::BOUND_NONE) && (rd_entry.key == s1_key_ff);
      pr_cut   = 1'b0;
      if (s1_not_root_ff && (rd_entry.depth >= s1_depth_ff)) begin
         unique case (rd_entry.bound)
            tt_pkg::BOUND_EXACT: pr_cut = 1'b1;
            tt_pkg::BOUND_LOWER: pr_cut = st_score >= s1_beta_ff;
            tt_pkg::BOUND_UPPER: pr_cut = st_score <= s1_alpha_ff;
            tt_pkg::BOUND_NONE:  pr_cut = 1'b0;
            default:             pr_cut = 1'b0;
         endcase
      end
      hit_c   = 1'b0;
      cut_c   = 1'b0;
      done_c  = 1'b0;
      move_c  = '0;
      score_c = '0;
      unique case (s1_cmd_ff)
         tt_pkg::CMD_PROBE: begin
            hit_c = pr_hit;
            cut_c = pr_hit && pr_cut;
            if (pr_hit) begin
               move_c = rd_entry.move;
            end
            if (pr_hit && pr_cut) begin
               score_c = rd_entry.score;
            end
         end
         tt_pkg::CMD_STORE,
         tt_pkg::CMD_CLEAR: done_c = 1'b1;
         tt_pkg::CMD_NOP:   done_c = 1'b0;
         default:           done_c = 1'b0;
      endcase
   end

   // ---------------- output register ----------------
   always_comb begin
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_hit_ff    <= hit_c;
         rsp_move_ff   <= move_c;
         rsp_cutoff_ff <= cut_c;
         rsp_score_ff  <= score_c;
         rsp_done_ff   <= done_c;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hit          = rsp_hit_ff;
   assign rsp_if.hash_move    = rsp_move_ff;
   assign rsp_if.cutoff       = rsp_cutoff_ff;
   assign rsp_if.cutoff_score = rsp_score_ff;
   assign rsp_if.done_res     = rsp_done_ff;

endmodule

// File: sim/tt_table_checker.sv
`timescale 1ns / 1ps
// Response checker for the transposition table core: snoops request, response and csr
// beats, keeps its own copy of the table and score limit, and counts response mismatches.
// Depends on tt_pkg and the tt_req_if / tt_rsp_if interfaces.
module tt_table_checker
   import tt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   tt_req_if                  req,
   tt_rsp_if                  rsp,
   output int                 outstanding,
   output int                 mismatches
);

   typedef struct packed {
      logic                      hit;
      logic [MOVE_W-1:0]         hash_move;
      logic                      cutoff;
      logic signed [SCORE_W-1:0] cutoff_score;
      logic                      done_res;
   } lookup_rsp_t;

   // absent slot == empty slot (bound none)
   entry_type         slots[int unsigned];
   logic [LIMIT_W-1:0] limit_copy;
   lookup_rsp_t       due_rsps[$];

   function automatic lookup_rsp_t table_access(
      cmd_type                   cmd,
      logic [KEY_W-1:0]          key,
      logic signed [DEPTH_W-1:0] depth,
      logic                      not_root,
      logic signed [WIN_W-1:0]   alpha,
      logic signed [WIN_W-1:0]   beta,
      logic signed [WIN_W-1:0]   best,
      logic [MOVE_W-1:0]         move
   );
      lookup_rsp_t r;
      entry_type   e;
      int unsigned idx;
      int          lim;
      int          s;
      bit          cut;
      r = '0;
      idx = int'(key[INDEX_W-1:0]);
      case (cmd)
         CMD_PROBE: begin
            if (slots.exists(idx)) begin
               e = slots[idx];
               if (e.bound != BOUND_NONE && e.key == key) begin
                  r.hit = 1'b1;
                  r.hash_move = e.move;
                  s = e.score;
                  cut = 1'b0;
                  if (not_root && e.depth >= depth)
                     cut = (e.bound == BOUND_EXACT) ||
                           (e.bound == BOUND_LOWER && s >= beta) ||
                           (e.bound == BOUND_UPPER && s <= alpha);
                  if (cut) begin
                     r.cutoff = 1'b1;
                     r.cutoff_score = e.score;
                  end
               end
            end
         end
         CMD_STORE: begin
            lim = int'(limit_copy);
            s = best;
            if (s > lim) s = lim;
            if (s < -lim) s = -lim;
            e.key = key;
            e.score = SCORE_W'(s);
            e.depth = depth;
            e.move = move;
            // bound uses the unclamped score
            if (best <= alpha)
               e.bound = BOUND_UPPER;
            else if (best >= beta)
               e.bound = BOUND_LOWER;
            else
               e.bound = BOUND_EXACT;
            slots[idx] = e;
            r.done_res = 1'b1;
         end
         CMD_CLEAR: begin
            slots.delete();
            r.done_res = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      lookup_rsp_t got;
      lookup_rsp_t want;
      int          errs;
      errs = 0;
      if (reset) begin
         slots.delete();
         due_rsps.delete();
         limit_copy = SCORE_LIMIT_RESET;
         outstanding <= 0;
         mismatches <= 0;
      end else begin
         if (csr_wr_en)
            limit_copy = csr_wr_data;
         if (rsp.valid && rsp.ready) begin
            got.hit = rsp.hit;
            got.hash_move = rsp.hash_move;
            got.cutoff = rsp.cutoff;
            got.cutoff_score = rsp.cutoff_score;
            got.done_res = rsp.done_res;
            if (due_rsps.size() == 0) begin
               $error("response beat with no request waiting");
               errs++;
            end else begin
               want = due_rsps.pop_front();
               errs += check_field("hit", want.hit, got.hit);
               errs += check_field("hash_move", want.hash_move, got.hash_move);
               errs += check_field("cutoff", want.cutoff, got.cutoff);
               errs += check_field("cutoff_score", want.cutoff_score, got.cutoff_score);
               errs += check_field("done_res", want.done_res, got.done_res);
            end
         end
         if (req.valid && req.ready)
            due_rsps.insert(due_rsps.size(),
                            table_access(cmd_type'(req.command), req.position_key,
                                         req.remaining_depth, req.not_root,
                                         req.window_low, req.window_high,
                                         req.best_score, req.best_move));
         outstanding <= due_rsps.size();
         mismatches <= mismatches + errs;
      end
   end

endmodule

// File: sim/search_transposition_table_core_test.sv
`timescale 1ns / 1ps
// Top of the transposition table testbench: clock, reset, request/response traffic with
// random idling, score limit writes and the verdict. Depends on tt_pkg, the tt_req_if /
// tt_rsp_if interfaces, the core and tt_table_checker.
module search_transposition_table_core_test;
   import tt_pkg::*;

   localparam int RANDOM_BEATS = 1000;
   localparam int PHASES       = 5;
   localparam int LIMIT_NS     = 30_000_000;

   typedef struct {
      cmd_type                   cmd;
      logic [KEY_W-1:0]          key;
      logic signed [DEPTH_W-1:0] depth;
      logic                      not_root;
      logic signed [WIN_W-1:0]   alpha;
      logic signed [WIN_W-1:0]   beta;
      logic signed [WIN_W-1:0]   best;
      logic [MOVE_W-1:0]         move;
   } tt_op_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;
   int                 outstanding;
   int                 mismatches;

   bit                 sender_no_gap;
   bit                 recv_no_stall;
   int                 hold_cycles;
   logic [LIMIT_W-1:0] cur_limit = SCORE_LIMIT_RESET;
   logic [KEY_W-1:0]   key_pool[16];
   tt_op_t             directed[$];

   tt_req_if req_if();
   tt_rsp_if rsp_if();

   search_transposition_table_core uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   tt_table_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_if),
      .rsp         (rsp_if),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always #5 clock = ~clock;

   initial begin
      #(LIMIT_NS);
      $display("[search_transposition_table_core] ERROR");
      $finish;
   end

   function automatic tt_op_t mk(cmd_type c, logic [KEY_W-1:0] k, int d, bit nr,
                                 int lo, int hi, int b, int mv);
      tt_op_t op;
      op.cmd = c;
      op.key = k;
      op.depth = DEPTH_W'(d);
      op.not_root = nr;
      op.alpha = WIN_W'(lo);
      op.beta = WIN_W'(hi);
      op.best = WIN_W'(b);
      op.move = MOVE_W'(mv);
      return op;
   endfunction

   task automatic queue_op(tt_op_t op);
      directed.insert(directed.size(), op);
   endtask

   // mostly keys crowded into a few slots so that replacement and tag misses happen
   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      k = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0)
         k[INDEX_W-1:0] = INDEX_W'($urandom_range(0, 31));
      return k;
   endfunction

   function automatic int pick_score();
      int v;
      case ($urandom_range(0, 4))
         0, 1: v = int'($urandom_range(0, 600)) - 300;
         2: v = int'($urandom_range(0, 131071)) - 65536;
         3: begin
            v = int'(cur_limit) + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1) == 0) v = -v;
         end
         default: v = ($urandom_range(0, 1) == 0) ? 65535 : -65536;
      endcase
      return v;
   endfunction

   function automatic tt_op_t random_op();
      tt_op_t op;
      int     slot;
      int     roll;
      int     sc;
      int     lo;
      slot = $urandom_range(0, 15);
      roll = $urandom_range(0, 99);
      if (roll < 5)
         op.cmd = CMD_NOP;
      else if (roll < 40)
         op.cmd = CMD_STORE;
      else
         op.cmd = CMD_PROBE;
      if (op.cmd == CMD_STORE && $urandom_range(0, 4) == 0)
         key_pool[slot] = fresh_key();
      op.key = key_pool[slot];
      if (op.cmd == CMD_PROBE) begin
         roll = $urandom_range(0, 99);
         if (roll < 12)
            op.key[KEY_W-1:INDEX_W] = (KEY_W-INDEX_W)'({$urandom, $urandom});
         else if (roll < 20)
            op.key = {$urandom, $urandom};
      end else if (op.cmd == CMD_NOP) begin
         op.key = {$urandom, $urandom};
      end
      op.depth = ($urandom_range(0, 9) < 7) ? DEPTH_W'($urandom_range(0, 12))
                                            : DEPTH_W'($urandom);
      op.not_root = ($urandom_range(0, 99) < 85);
      op.move = MOVE_W'($urandom);
      sc = pick_score();
      op.best = WIN_W'(sc);
      if ($urandom_range(0, 4) == 0) begin
         op.alpha = WIN_W'($urandom);
         op.beta = WIN_W'($urandom);
      end else begin
         lo = sc + int'($urandom_range(0, 100)) - 50;
         op.alpha = WIN_W'(lo);
         op.beta = WIN_W'(lo + int'($urandom_range(1, 100)));
      end
      return op;
   endfunction

   // valid is left high after the beat; a gap in the next call or wait_drained lowers it
   task automatic send_beat(tt_op_t op);
      int gap;
      gap = sender_no_gap ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= op.cmd;
      req_if.position_key <= op.key;
      req_if.remaining_depth <= op.depth;
      req_if.not_root <= op.not_root;
      req_if.window_low <= op.alpha;
      req_if.window_high <= op.beta;
      req_if.best_score <= op.best;
      req_if.best_move <= op.move;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      cur_limit = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // response side
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = recv_no_stall ? 0 : $urandom_range(0, 9);
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      tt_op_t             op;
      logic [LIMIT_W-1:0] phase_limit[PHASES];
      logic [KEY_W-1:0]   key_a;
      logic [KEY_W-1:0]   key_b;
      logic [KEY_W-1:0]   key_c;
      int                 sent;

      req_if.valid = 1'b0;
      req_if.command = CMD_PROBE;
      req_if.position_key = '0;
      req_if.remaining_depth = '0;
      req_if.not_root = 1'b0;
      req_if.window_low = '0;
      req_if.window_high = '0;
      req_if.best_score = '0;
      req_if.best_move = '0;
      foreach (key_pool[i]) key_pool[i] = fresh_key();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      key_a = '1;
      key_b = 64'h0123_4567_89AB_0001;
      key_c = 64'h8000_0000_0000_0002;

      // empty slot with key zero must miss
      queue_op(mk(CMD_PROBE, '0, 0, 1, -100, 100, 0, 0));
      queue_op(mk(CMD_NOP, '1, -1, 1, -1, -1, -1, 65535));
      // lower bound, score clamped to the limit
      queue_op(mk(CMD_STORE, key_a, 127, 0, -65536, 65535, 65535, 65535));
      queue_op(mk(CMD_PROBE, key_a, -128, 1, 0, 32000, 0, 0));
      queue_op(mk(CMD_PROBE, key_a, 127, 0, 0, 0, 0, 0));
      queue_op(mk(CMD_PROBE, key_a, 127, 1, 0, 32001, 0, 0));
      // upper bound at the negative extremes
      queue_op(mk(CMD_STORE, key_b, -128, 1, -65536, 65535, -65536, 0));
      queue_op(mk(CMD_PROBE, key_b, -128, 1, -32000, 0, 0, 0));
      queue_op(mk(CMD_PROBE, key_b, -127, 1, -32000, 0, 0, 0));
      queue_op(mk(CMD_PROBE, key_b, -128, 1, -32001, 0, 0, 0));
      queue_op(mk(CMD_PROBE, key_b ^ (64'h1 << 40), -128, 1, 0, 0, 0, 0));
      // exact bound
      queue_op(mk(CMD_STORE, key_c, 0, 1, -10, 10, 5, 16'h1234));
      queue_op(mk(CMD_PROBE, key_c, 0, 1, -10, 10, 0, 0));
      queue_op(mk(CMD_PROBE, key_c, 1, 1, -10, 10, 0, 0));
      // score equal to alpha, then equal to beta
      queue_op(mk(CMD_STORE, key_c, 3, 1, 7, 20, 7, 16'h00FF));
      queue_op(mk(CMD_PROBE, key_c, 3, 1, 7, 20, 0, 0));
      queue_op(mk(CMD_STORE, '0, 5, 1, -20, 9, 9, 16'hFF00));
      queue_op(mk(CMD_PROBE, '0, 5, 1, -20, 9, 0, 0));
      queue_op(mk(CMD_CLEAR, '1, 0, 0, 0, 0, 0, 0));
      queue_op(mk(CMD_PROBE, key_a, -128, 1, 0, 0, 0, 0));
      queue_op(mk(CMD_PROBE, '0, -128, 1, 0, 0, 0, 0));
      queue_op(mk(CMD_PROBE, key_c, -128, 1, 0, 0, 0, 0));
      queue_op(mk(CMD_STORE, key_c, 2, 1, -5, 5, 3, 16'hBEEF));
      queue_op(mk(CMD_PROBE, key_c, 2, 1, -5, 5, 0, 0));
      foreach (directed[i]) send_beat(directed[i]);

      phase_limit[0] = '0;
      phase_limit[1] = '1;
      phase_limit[2] = LIMIT_W'(100);
      phase_limit[3] = LIMIT_W'($urandom);
      phase_limit[4] = SCORE_LIMIT_RESET;

      for (int ph = 0; ph < PHASES; ph++) begin
         write_limit(phase_limit[ph]);
         sent = 0;
         // long receiver hold while the sender keeps pushing back to back
         if (ph == 1) hold_cycles = 300;
         while (sent < RANDOM_BEATS / PHASES) begin
            sender_no_gap = (ph == 1 && sent < 40) || (ph == 2 && sent >= 50 && sent < 110);
            recv_no_stall = (ph == 2 && sent >= 50 && sent < 110);
            if (ph == 3 && sent == 100) wait_drained();
            op = random_op();
            send_beat(op);
            if (op.cmd != CMD_NOP) sent++;
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("[search_transposition_table_core] OK");
      else
         $display("[search_transposition_table_core] ERROR");
      $finish;
   end

endmodule
